### hw/rtl/mdc_pkg.sv
package mdc_pkg;

  localparam int HISTORY_DEPTH_DEF   = 4096;
  localparam int SINE_TABLE_SIZE_DEF = 1024;
  localparam int SAMPLE_WIDTH_DEF    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int DELAY_W    = 12;
  localparam int MAXD_W     = 8;
  localparam int KNOB_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 20;
  localparam int PHASE_W    = 32;
  localparam int SINE_W     = 15;
  localparam int GAIN_FRAC  = 15;
  localparam int OFFS_SHIFT = 31;
  localparam int DM_W       = MAXD_W + KNOB_W;
  localparam int MAG_W      = DM_W + SINE_W;
  localparam int OFFS_W     = MAG_W - OFFS_SHIFT;

  localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(2205);
  localparam logic [MAXD_W-1:0]  MAXD_RST  = MAXD_W'(44);
  localparam logic [KNOB_W-1:0]  KNOB_RST  = '0;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = '0;
  localparam logic [STEP_W-1:0]  STEP_RST  = '0;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY      = 3'd0,
    CFG_MAX_DEPTH  = 3'd1,
    CFG_DEPTH_KNOB = 3'd2,
    CFG_WET_GAIN   = 3'd3,
    CFG_PHASE_STEP = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic mag;
    logic addr;
    logic mix;
  } mdc_cmd_t;

  typedef struct packed {
    logic out_busy;
  } mdc_stat_t;

  // quarter-wave sine magnitude, argument u / 2^30 of pi/2, odd taylor series to x^9
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] q;
    x  = (u * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    a  = Q30_ONE - x2 / 64'd72;
    b  = Q30_ONE - ((x2 * a) >> 30) / 64'd42;
    c  = Q30_ONE - ((x2 * b) >> 30) / 64'd20;
    d  = Q30_ONE - ((x2 * c) >> 30) / 64'd6;
    s  = (x * d) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[SINE_W-1:0];
  endfunction

endpackage

### hw/rtl/mdc_ram.sv
module mdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mdc_ctrl.sv
module mdc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  mdc_pkg::mdc_stat_t stat_i,
  output mdc_pkg::mdc_cmd_t  cmd_o
);
  import mdc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAG,
    ST_ADDR,
    ST_MIX
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            state_q <= ST_MAG;
            ready_q <= 1'b0;
          end
        end
        ST_MAG: begin
          state_q <= ST_ADDR;
        end
        ST_ADDR: begin
          state_q <= ST_MIX;
        end
        ST_MIX: begin
          if (!stat_i.out_busy) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
      endcase
    end
  end

  assign s_tready_o = ready_q;
  assign cmd_o.load = s_tvalid_i & ready_q;
  assign cmd_o.mag  = (state_q == ST_MAG);
  assign cmd_o.addr = (state_q == ST_ADDR);
  assign cmd_o.mix  = (state_q == ST_MIX) & ~stat_i.out_busy;

endmodule

### hw/rtl/mdc_datapath.sv
module mdc_datapath #(
  parameter int HISTORY_DEPTH   = mdc_pkg::HISTORY_DEPTH_DEF,
  parameter int SINE_TABLE_SIZE = mdc_pkg::SINE_TABLE_SIZE_DEF,
  parameter int SAMPLE_WIDTH    = mdc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mdc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mdc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  mdc_pkg::mdc_cmd_t                 cmd_i,
  output mdc_pkg::mdc_stat_t                stat_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i
);
  import mdc_pkg::*;

  localparam int AW      = $clog2(HISTORY_DEPTH);
  localparam int IW      = $clog2(SINE_TABLE_SIZE);
  localparam int QUARTER = SINE_TABLE_SIZE / 4;
  localparam int JW      = IW - 1;
  localparam int PW      = (AW > DELAY_W) ? AW : DELAY_W;
  localparam int SW      = SAMPLE_WIDTH;
  localparam int PROD_W  = SW + GAIN_W + 1;
  localparam int WET_W   = SW + 2;
  localparam int SUM_W   = SW + 3;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  // configuration registers
  logic [DELAY_W-1:0] delay_q;
  logic [MAXD_W-1:0]  maxd_q;
  logic [KNOB_W-1:0]  knob_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [STEP_W-1:0]  step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RST;
      maxd_q  <= MAXD_RST;
      knob_q  <= KNOB_RST;
      gain_q  <= GAIN_RST;
      step_q  <= STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DELAY:      delay_q <= cfg_wdata_i[DELAY_W-1:0];
        CFG_MAX_DEPTH:  maxd_q  <= cfg_wdata_i[MAXD_W-1:0];
        CFG_DEPTH_KNOB: knob_q  <= cfg_wdata_i[KNOB_W-1:0];
        CFG_WET_GAIN:   gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        CFG_PHASE_STEP: step_q  <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // quarter-wave sine table
  logic [SINE_W-1:0] sine_lut [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_lut
    localparam logic [63:0] U = (64'(k) << 30) / QUARTER;
    assign sine_lut[k] = quarter_sine(U);
  end

  // write pointer, fill flag and lfo
  logic [AW-1:0]      wp_q;
  logic               full_q;
  logic [PHASE_W-1:0] phase_q;
  logic [PHASE_W-1:0] phase_d;

  assign phase_d = phase_q + PHASE_W'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      full_q  <= 1'b0;
      phase_q <= '0;
    end else begin
      if (cmd_i.load) begin
        phase_q <= phase_d;
      end
      if (cmd_i.mix) begin
        wp_q <= wp_q + AW'(1);
        if (wp_q == AW'(HISTORY_DEPTH - 1)) begin
          full_q <= 1'b1;
        end
      end
    end
  end

  // table index with quadrant fold
  logic [IW-1:0] tab_idx;
  logic [JW-1:0] lut_idx;

  assign tab_idx = phase_d[PHASE_W-1 -: IW];
  assign lut_idx = tab_idx[IW-2] ? (JW'(QUARTER) - {1'b0, tab_idx[IW-3:0]})
                                 : {1'b0, tab_idx[IW-3:0]};

  logic signed [SW-1:0] x_q;
  logic [SINE_W-1:0]    sine_q;
  logic                 neg_q;
  logic [DM_W-1:0]      dm_q;
  logic [MAG_W-1:0]     mag_q;
  logic                 tap_ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= sample_in_i;
      sine_q <= sine_lut[lut_idx];
      neg_q  <= tab_idx[IW-1];
      dm_q   <= DM_W'(knob_q) * DM_W'(maxd_q);
    end
    if (cmd_i.mag) begin
      mag_q <= MAG_W'(dm_q) * MAG_W'(sine_q);
    end
  end

  // tap address
  logic [OFFS_W-1:0] off_mag;
  logic [PW-1:0]     off_ext;
  logic [PW-1:0]     pos_full;
  logic [AW-1:0]     pos;

  assign off_mag  = mag_q[MAG_W-1:OFFS_SHIFT];
  assign off_ext  = neg_q ? (PW'(0) - PW'(off_mag)) : PW'(off_mag);
  assign pos_full = PW'(wp_q) - PW'(delay_q) + off_ext;
  assign pos      = pos_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr) begin
      tap_ok_q <= full_q | (pos <= wp_q);
    end
  end

  logic [SW-1:0] rdata;

  mdc_ram #(
    .WIDTH (SW),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (wp_q),
    .wdata_i (sample_in_i),
    .re_i    (cmd_i.addr),
    .raddr_i (pos),
    .rdata_o (rdata)
  );

  // wet mix and saturation
  logic signed [SW-1:0]     delayed;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [WET_W-1:0]  wet;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SW-1:0]     sat;

  assign delayed = tap_ok_q ? $signed(rdata) : '0;
  assign prod    = $signed({1'b0, gain_q}) * PROD_W'(delayed);
  assign prod_sh = prod >>> GAIN_FRAC;
  assign wet     = prod_sh[WET_W-1:0];
  assign sum     = SUM_W'(x_q) + SUM_W'(wet);

  always_comb begin
    priority if (sum > SAT_MAX) begin
      sat = SAT_MAX[SW-1:0];
    end else if (sum < SAT_MIN) begin
      sat = SAT_MIN[SW-1:0];
    end else begin
      sat = sum[SW-1:0];
    end
  end

  // output register
  logic signed [SW-1:0] out_q;
  logic                 out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.mix) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix) begin
      out_q <= sat;
    end
  end

  assign stat_o.out_busy = out_valid_q & ~out_ready_i;
  assign sample_out_o    = out_q;
  assign out_valid_o     = out_valid_q;

endmodule

### hw/rtl/modulated_delay_chorus.sv
// latency: output valid after the controller's mag, addr and mix states, later if the output is stalled
// throughput: a new sample is taken only after the previous one is mixed, set by the controller sequence
//   (table read, offset multiply, history read, wet multiply and saturate)
// reset: asynchronous active low, clears registers to defaults, pointer and lfo to zero
// history reads of never-written entries return zero by a fill flag, no clearing pass
module modulated_delay_chorus #(
  parameter int HISTORY_DEPTH   = mdc_pkg::HISTORY_DEPTH_DEF,
  parameter int SINE_TABLE_SIZE = mdc_pkg::SINE_TABLE_SIZE_DEF,
  parameter int SAMPLE_WIDTH    = mdc_pkg::SAMPLE_WIDTH_DEF,
  parameter int TDATA_W         = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mdc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [TDATA_W-1:0]             s_tdata_i,  // sample_in
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [TDATA_W-1:0]             m_tdata_o   // sample_out
);
  import mdc_pkg::*;

  mdc_cmd_t  cmd;
  mdc_stat_t stat;

  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  mdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mdc_datapath #(
    .HISTORY_DEPTH   (HISTORY_DEPTH),
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .sample_in_i  ($signed(s_tdata_i[SAMPLE_WIDTH-1:0])),
    .sample_out_o (sample_out),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i)
  );

  assign m_tdata_o = TDATA_W'($unsigned(sample_out));

endmodule

### hw/rtl/mdc_checker.sv
module mdc_props #(
  parameter int TDATA_W = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_tvalid_i,
  input logic               s_tready_o,
  input logic [TDATA_W-1:0] s_tdata_i,
  input logic               m_tvalid_o,
  input logic               m_tready_i,
  input logic [TDATA_W-1:0] m_tdata_o
);

  logic s_xfer;
  assign s_xfer = s_tvalid_i & s_tready_o;

  // one sample in flight: ready drops after a transfer
  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_tready_o)
    else $error("input ready still high after transfer");

  // controller sequence keeps input closed until the mix step
  a_ready_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |-> ##3 !s_tready_o)
    else $error("input reopened before result was formed");

  // a result is present after the mag, addr and mix states that follow an input transfer
  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |-> ##4 m_tvalid_o)
    else $error("no result four cycles after input transfer");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("stalled output changed");

endmodule

bind modulated_delay_chorus mdc_props #(.TDATA_W(TDATA_W)) u_mdc_checker (.*);

### sim/mdc_checker.sv
module mdc_checker
  import mdc_pkg::*;
#(
  parameter int TD_W = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [TD_W-1:0]       s_tdata_i,  // sample_in
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [TD_W-1:0]       m_tdata_i,  // sample_out
  output int                    errors_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     HIST_AW  = $clog2(HISTORY_DEPTH_DEF);
  localparam int     TAB_AW   = $clog2(SINE_TABLE_SIZE_DEF);
  localparam int     SW       = SAMPLE_WIDTH_DEF;
  localparam longint SMP_MAX  = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMP_MIN  = -SMP_MAX - 1;
  localparam int     SINE_MAX = 32767;

  typedef logic signed [SW-1:0] sample_t;

  int                  sine_tab [SINE_TABLE_SIZE_DEF];
  sample_t             hist [HISTORY_DEPTH_DEF];
  logic [HIST_AW-1:0]  wr_ptr;
  logic [PHASE_W-1:0]  lfo;
  logic [DELAY_W-1:0]  delay_r;
  logic [MAXD_W-1:0]   maxd_r;
  logic [KNOB_W-1:0]   knob_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [STEP_W-1:0]   step_r;
  sample_t             expected_q[$];
  sample_t             want;
  sample_t             got;

  // sine of table slot k, quadrant fold plus odd series to x^9, rounded to q1.15
  function automatic int sine_entry(int k);
    int unsigned divs [4] = '{72, 42, 20, 6};
    logic [63:0] turn;
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] poly;
    logic [63:0] mag;
    logic [1:0]  quad;
    turn = (64'(k) << 32) / 64'(SINE_TABLE_SIZE_DEF);
    quad = turn[31:30];
    frac = {34'd0, turn[29:0]};
    if (quad[0]) begin
      frac = Q30_ONE - frac;
    end
    x    = (frac * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    poly = Q30_ONE;
    foreach (divs[i]) begin
      poly = Q30_ONE - ((x2 * poly) >> 30) / 64'(divs[i]);
    end
    mag = (((x * poly) >> 30) + 64'd16384) >> 15;
    if (mag > 64'(SINE_MAX)) begin
      mag = 64'(SINE_MAX);
    end
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  initial begin
    for (int k = 0; k < SINE_TABLE_SIZE_DEF; k++) begin
      sine_tab[k] = sine_entry(k);
    end
  end

  // store the dry sample, advance the lfo, read the modulated tap, mix and advance the write pointer
  function automatic sample_t chorus_mix(sample_t dry);
    int                 sine;
    longint             offs;
    longint             wet;
    longint             sum;
    logic [HIST_AW-1:0] tap;
    hist[wr_ptr] = dry;
    lfo  = lfo + PHASE_W'(step_r);
    sine = sine_tab[lfo[PHASE_W-1 -: TAB_AW]];
    offs = (longint'(knob_r) * longint'(maxd_r) * longint'(sine < 0 ? -sine : sine))
           >>> OFFS_SHIFT;
    if (sine < 0) begin
      offs = -offs;
    end
    tap  = HIST_AW'(longint'(wr_ptr) - longint'(delay_r) + offs);
    wet  = (longint'(gain_r) * longint'(hist[tap])) >>> GAIN_FRAC;
    sum  = longint'(dry) + wet;
    if (sum > SMP_MAX) begin
      sum = SMP_MAX;
    end
    if (sum < SMP_MIN) begin
      sum = SMP_MIN;
    end
    wr_ptr = wr_ptr + 1'b1;
    return sample_t'(sum);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (hist[i]) begin
        hist[i] = '0;
      end
      wr_ptr  = '0;
      lfo     = '0;
      delay_r = DELAY_RST;
      maxd_r  = MAXD_RST;
      knob_r  = KNOB_RST;
      gain_r  = GAIN_RST;
      step_r  = STEP_RST;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DELAY:      delay_r = cfg_wdata_i[DELAY_W-1:0];
          CFG_MAX_DEPTH:  maxd_r  = cfg_wdata_i[MAXD_W-1:0];
          CFG_DEPTH_KNOB: knob_r  = cfg_wdata_i[KNOB_W-1:0];
          CFG_WET_GAIN:   gain_r  = cfg_wdata_i[GAIN_W-1:0];
          CFG_PHASE_STEP: step_r  = cfg_wdata_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_q.push_back(chorus_mix(sample_t'(s_tdata_i[SW-1:0])));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = sample_t'(m_tdata_i[SW-1:0]);
        if (expected_q.size() == 0) begin
          errors_o++;
          $error("sample_out: no transfer expected, actual %0d", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors_o++;
            $error("sample_out: expected %0d, actual %0d", want, got);
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mdc_pkg::*;

  localparam int TD_W       = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8;
  localparam int RAND_PHASES = 16;
  localparam int PHASE_ITEMS = 111;
  localparam int RX_HOLD     = 300;
  localparam int SETTLE      = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = '1;
  localparam logic [STEP_W-1:0]    STEP_MAX = '1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_tvalid_i  = 1'b0;
  logic                  s_tready_o;
  logic [TD_W-1:0]       s_tdata_i   = '0;
  logic                  m_tvalid_o;
  logic                  m_tready_i  = 1'b0;
  logic [TD_W-1:0]       m_tdata_o;

  int check_errors;
  int check_pending;
  int tx_gap_hi = 7;
  int hold_req  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  modulated_delay_chorus DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  mdc_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_i  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_i  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_i   (m_tdata_o),
    .errors_o    (check_errors),
    .pending_o   (check_pending)
  );

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input int width);
    logic [CFG_DATA_W-1:0] keep;
    keep = {CFG_DATA_W{1'b1}} >> (CFG_DATA_W - width);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= (CFG_DATA_W'($urandom) & ~keep) | (val & keep);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_regs(input int delay, input int maxd, input int knob, input int gain,
                          input int step);
    write_reg(CFG_DELAY, CFG_DATA_W'(delay), DELAY_W);
    write_reg(CFG_MAX_DEPTH, CFG_DATA_W'(maxd), MAXD_W);
    write_reg(CFG_DEPTH_KNOB, CFG_DATA_W'(knob), KNOB_W);
    write_reg(CFG_WET_GAIN, CFG_DATA_W'(gain), GAIN_W);
    write_reg(CFG_PHASE_STEP, CFG_DATA_W'(step), STEP_W);
  endtask

  task automatic send_sample(input logic [TD_W-1:0] smp);
    int gap;
    gap = $urandom_range(0, tx_gap_hi);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= smp;
    do @(posedge clk_i); while (!s_tready_o);
    @(negedge clk_i);
  endtask

  // wait for every expected transfer, then let the pipeline go quiet
  task automatic settle();
    s_tvalid_i <= 1'b0;
    while (check_pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [TD_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return TD_W'($urandom);
    endcase
  endfunction

  initial begin : stim
    int delay;
    int maxd;
    int knob;
    int gain;
    int step;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // register defaults, no wet path
    tx_gap_hi = 0;
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    settle();

    // unity gain, one sample back: both saturation directions
    tx_gap_hi = 7;
    set_regs(1, 0, 0, 32768, 0);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    settle();

    // zero delay reads the sample just written, gain near two
    set_regs(0, 0, 0, 65535, 0);
    send_sample(16'd100);
    send_sample(-16'sd100);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    settle();

    // delay plus excursion past the history, write to an unused index
    set_regs(4095, 255, 65535, 32768, STEP_MAX);
    write_reg(CFG_NONE, CFG_DATA_W'($urandom), CFG_DATA_W);
    send_sample(16'h1234);
    send_sample(16'hC000);
    send_sample(16'h7FFF);
    settle();

    // short delay with full excursion, tap at or ahead of the write position
    set_regs(5, 255, 65535, 40000, STEP_MAX);
    send_sample(16'h4000);
    send_sample(16'h8001);
    send_sample(16'h7FFE);
    send_sample(16'h0000);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 4))
        0:       delay = 0;
        1:       delay = 1;
        2:       delay = 4095;
        3:       delay = $urandom_range(0, 300);
        default: delay = $urandom_range(0, 4095);
      endcase
      case ($urandom_range(0, 2))
        0:       maxd = 0;
        1:       maxd = 255;
        default: maxd = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 2))
        0:       knob = 0;
        1:       knob = 65535;
        default: knob = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 3))
        0:       gain = 0;
        1:       gain = 32768;
        2:       gain = 65535;
        default: gain = $urandom_range(0, 65535);
      endcase
      step = (p % 4 == 3) ? $urandom_range(0, 1048575) : int'(STEP_MAX);
      set_regs(delay, maxd, knob, gain, step);
      tx_gap_hi = (p % 3 == 1) ? 0 : 7;
      if (p == 2 || p == 9) begin
        tx_gap_hi = 0;
        hold_req++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_sample());
      end
      settle();
    end

    repeat (20) @(negedge clk_i);
    if (check_errors == 0 && check_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : rx_side
    int gap;
    int gap_hi;
    int n_got;
    int holds_done;
    gap_hi     = 7;
    n_got      = 0;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req > holds_done) begin
        holds_done++;
        gap = RX_HOLD;
      end else begin
        gap = $urandom_range(0, gap_hi);
      end
      if (gap > 0) begin
        m_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      @(negedge clk_i);
      n_got++;
      if (n_got % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_hi = 0;
          1:       gap_hi = 3;
          default: gap_hi = 7;
        endcase
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
hw/rtl/mdc_pkg.sv
hw/rtl/mdc_ram.sv
hw/rtl/mdc_ctrl.sv
hw/rtl/mdc_datapath.sv
hw/rtl/modulated_delay_chorus.sv
hw/rtl/mdc_checker.sv
sim/mdc_checker.sv
sim/tb.sv
